// File: hdl/link_failover_controller_unit_assert.svh
// assertion macros shared by the link failover controller rtl
`ifndef LINK_FAILOVER_CONTROLLER_UNIT_ASSERT_SVH
`define LINK_FAILOVER_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define LFC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfc same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define LFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfc next-cycle check failed");

`endif

// File: hdl/lfc_pkg.sv
// types, codes and reset values for the link failover controller
package lfc_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned KA_W   = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 5;

  typedef enum logic [1:0] {
    IF_NONE = 2'd0,
    IF_ETH  = 2'd1,
    IF_WIFI = 2'd2,
    IF_OFF  = 2'd3
  } iface_t;

  typedef enum logic [3:0] {
    ST_START           = 4'd0,
    ST_TRY_ETH         = 4'd1,
    ST_WAIT_ETH_READY  = 4'd2,
    ST_WAIT_ETH_CLOUD  = 4'd3,
    ST_ETH_CLOUD_UP    = 4'd4,
    ST_TRY_WIFI        = 4'd5,
    ST_WAIT_WIFI_READY = 4'd6,
    ST_WAIT_WIFI_CLOUD = 4'd7,
    ST_WIFI_CLOUD_UP   = 4'd8,
    ST_WIFI_WAIT_DOWN  = 4'd9,
    ST_NO_CONNECT      = 4'd10
  } state_t;

  typedef enum logic [1:0] {
    LED_KEEP    = 2'd0,
    LED_YELLOW  = 2'd1,
    LED_DEFAULT = 2'd2
  } led_t;

  typedef enum logic [2:0] {
    REG_ETH_LINK_TO   = 3'd0,
    REG_ETH_CLOUD_TO  = 3'd1,
    REG_WIFI_LINK_TO  = 3'd2,
    REG_WIFI_CLOUD_TO = 3'd3,
    REG_ETH_RETRY     = 3'd4,
    REG_ETH_KA        = 3'd5,
    REG_WIFI_KA       = 3'd6
  } reg_idx_t;

  localparam logic [TIME_W-1:0] RST_ETH_LINK_TO   = 32'd30000;
  localparam logic [TIME_W-1:0] RST_ETH_CLOUD_TO  = 32'd60000;
  localparam logic [TIME_W-1:0] RST_WIFI_LINK_TO  = 32'd30000;
  localparam logic [TIME_W-1:0] RST_WIFI_CLOUD_TO = 32'd60000;
  localparam logic [TIME_W-1:0] RST_ETH_RETRY     = 32'd300000;
  localparam logic [KA_W-1:0]   RST_ETH_KA        = 16'd25;
  localparam logic [KA_W-1:0]   RST_WIFI_KA       = 16'd25;

  typedef struct packed {
    logic              auto_select;
    logic              eth_adapter_present;
    logic              eth_link_ready;
    logic              wifi_link_ready;
    logic              cloud_connected;
    logic              cloud_disconnected;
    logic [TIME_W-1:0] now_ms;
  } tick_t;

  typedef struct packed {
    logic [TIME_W-1:0] eth_link_timeout_ms;
    logic [TIME_W-1:0] eth_cloud_timeout_ms;
    logic [TIME_W-1:0] wifi_link_timeout_ms;
    logic [TIME_W-1:0] wifi_cloud_timeout_ms;
    logic [TIME_W-1:0] eth_retry_period_ms;
    logic [KA_W-1:0]   eth_keepalive_s;
    logic [KA_W-1:0]   wifi_keepalive_s;
  } cfg_t;

  typedef struct packed {
    state_t            state;
    iface_t            iface;
    logic [TIME_W-1:0] entry_time;
    logic              adapter_seen;
  } ctx_t;

  typedef struct packed {
    iface_t          active_interface;
    logic            interface_changed;
    iface_t          previous_interface;
    logic            eth_connect;
    logic            eth_disconnect;
    logic            wifi_connect;
    logic            wifi_disconnect;
    logic            cloud_connect;
    logic            cloud_disconnect;
    logic            keepalive_write;
    logic [KA_W-1:0] keepalive_seconds;
    led_t            led_theme;
  } res_t;

endpackage

// File: hdl/lfc_fsm.sv
// next-state and command logic for one poll tick
module lfc_fsm (
  input  lfc_pkg::tick_t tick,
  input  lfc_pkg::cfg_t  cfg,
  input  lfc_pkg::ctx_t  ctx,
  output lfc_pkg::ctx_t  ctx_nxt,
  output lfc_pkg::res_t  res
);

  logic [lfc_pkg::TIME_W-1:0] limit;
  logic [lfc_pkg::TIME_W-1:0] age;
  logic                       elapsed;
  lfc_pkg::iface_t            new_if;

  // only one timeout matters in each state
  always_comb begin
    case (ctx.state)
      lfc_pkg::ST_WAIT_ETH_READY:  limit = cfg.eth_link_timeout_ms;
      lfc_pkg::ST_WAIT_ETH_CLOUD:  limit = cfg.eth_cloud_timeout_ms;
      lfc_pkg::ST_WAIT_WIFI_READY: limit = cfg.wifi_link_timeout_ms;
      lfc_pkg::ST_WAIT_WIFI_CLOUD: limit = cfg.wifi_cloud_timeout_ms;
      lfc_pkg::ST_WIFI_CLOUD_UP:   limit = cfg.eth_retry_period_ms;
      default:                     limit = cfg.eth_link_timeout_ms;
    endcase
  end

  assign age     = tick.now_ms - ctx.entry_time;
  assign elapsed = (age >= limit);

  always_comb begin
    ctx_nxt = ctx;
    res     = '0;
    new_if  = ctx.iface;
    case (ctx.state)
      lfc_pkg::ST_TRY_ETH: begin
        res.led_theme        = lfc_pkg::LED_YELLOW;
        new_if               = lfc_pkg::IF_NONE;
        ctx_nxt.entry_time   = tick.now_ms;
        res.wifi_disconnect  = 1'b1;
        res.eth_connect      = 1'b1;
        ctx_nxt.state        = lfc_pkg::ST_WAIT_ETH_READY;
      end
      lfc_pkg::ST_WAIT_ETH_READY: begin
        if (!tick.auto_select) begin
          res.eth_disconnect = 1'b1;
          new_if             = lfc_pkg::IF_OFF;
          ctx_nxt.state      = lfc_pkg::ST_NO_CONNECT;
        end else if (tick.eth_link_ready) begin
          new_if            = lfc_pkg::IF_ETH;
          res.cloud_connect = 1'b1;
          ctx_nxt.state     = lfc_pkg::ST_WAIT_ETH_CLOUD;
        end else if (elapsed) begin
          new_if        = lfc_pkg::IF_NONE;
          ctx_nxt.state = lfc_pkg::ST_TRY_WIFI;
        end
      end
      lfc_pkg::ST_WAIT_ETH_CLOUD: begin
        if (!tick.auto_select) begin
          res.eth_disconnect = 1'b1;
          new_if             = lfc_pkg::IF_OFF;
          ctx_nxt.state      = lfc_pkg::ST_NO_CONNECT;
        end else if (tick.cloud_connected) begin
          new_if                = lfc_pkg::IF_ETH;
          res.keepalive_write   = 1'b1;
          res.keepalive_seconds = cfg.eth_keepalive_s;
          ctx_nxt.entry_time    = tick.now_ms;
          ctx_nxt.state         = lfc_pkg::ST_ETH_CLOUD_UP;
        end else if (elapsed) begin
          res.cloud_disconnect = 1'b1;
          res.eth_disconnect   = 1'b1;
          ctx_nxt.state        = lfc_pkg::ST_TRY_WIFI;
        end
      end
      lfc_pkg::ST_ETH_CLOUD_UP: begin
        if (!tick.auto_select) begin
          res.cloud_disconnect = 1'b1;
          res.eth_disconnect   = 1'b1;
          new_if               = lfc_pkg::IF_OFF;
          ctx_nxt.state        = lfc_pkg::ST_NO_CONNECT;
        end else if (!tick.cloud_connected) begin
          new_if             = lfc_pkg::IF_NONE;
          ctx_nxt.entry_time = tick.now_ms;
          ctx_nxt.state      = lfc_pkg::ST_WAIT_ETH_CLOUD;
        end
      end
      lfc_pkg::ST_TRY_WIFI: begin
        new_if             = lfc_pkg::IF_NONE;
        res.led_theme      = lfc_pkg::LED_DEFAULT;
        ctx_nxt.entry_time = tick.now_ms;
        res.eth_disconnect = 1'b1;
        res.wifi_connect   = 1'b1;
        ctx_nxt.state      = lfc_pkg::ST_WAIT_WIFI_READY;
      end
      lfc_pkg::ST_WAIT_WIFI_READY: begin
        if (!tick.auto_select) begin
          new_if        = lfc_pkg::IF_OFF;
          ctx_nxt.state = lfc_pkg::ST_NO_CONNECT;
        end else if (tick.wifi_link_ready) begin
          new_if            = lfc_pkg::IF_WIFI;
          res.cloud_connect = 1'b1;
          ctx_nxt.state     = lfc_pkg::ST_WAIT_WIFI_CLOUD;
        end else if (elapsed && ctx.adapter_seen) begin
          new_if        = lfc_pkg::IF_NONE;
          ctx_nxt.state = lfc_pkg::ST_TRY_ETH;
        end
      end
      lfc_pkg::ST_WAIT_WIFI_CLOUD: begin
        if (!tick.auto_select) begin
          res.cloud_disconnect = 1'b1;
          res.wifi_disconnect  = 1'b1;
          new_if               = lfc_pkg::IF_OFF;
          ctx_nxt.state        = lfc_pkg::ST_NO_CONNECT;
        end else if (tick.cloud_connected) begin
          res.keepalive_write   = 1'b1;
          res.keepalive_seconds = cfg.wifi_keepalive_s;
          new_if                = lfc_pkg::IF_WIFI;
          ctx_nxt.entry_time    = tick.now_ms;
          ctx_nxt.state         = lfc_pkg::ST_WIFI_CLOUD_UP;
        end else if (elapsed && ctx.adapter_seen) begin
          res.cloud_disconnect = 1'b1;
          new_if               = lfc_pkg::IF_NONE;
          ctx_nxt.state        = lfc_pkg::ST_TRY_ETH;
        end
      end
      lfc_pkg::ST_WIFI_CLOUD_UP: begin
        if (!tick.auto_select) begin
          res.cloud_disconnect = 1'b1;
          res.wifi_disconnect  = 1'b1;
          new_if               = lfc_pkg::IF_OFF;
          ctx_nxt.state        = lfc_pkg::ST_NO_CONNECT;
        end else if (!tick.cloud_connected) begin
          new_if             = lfc_pkg::IF_NONE;
          ctx_nxt.entry_time = tick.now_ms;
          ctx_nxt.state      = lfc_pkg::ST_WAIT_WIFI_CLOUD;
        end else if (elapsed && ctx.adapter_seen) begin
          res.cloud_disconnect = 1'b1;
          new_if               = lfc_pkg::IF_NONE;
          ctx_nxt.state        = lfc_pkg::ST_WIFI_WAIT_DOWN;
        end
      end
      lfc_pkg::ST_WIFI_WAIT_DOWN: begin
        if (!tick.auto_select) begin
          res.cloud_disconnect = 1'b1;
          res.wifi_disconnect  = 1'b1;
          new_if               = lfc_pkg::IF_OFF;
          ctx_nxt.state        = lfc_pkg::ST_NO_CONNECT;
        end else if (tick.cloud_disconnected) begin
          ctx_nxt.state = lfc_pkg::ST_TRY_ETH;
        end
      end
      lfc_pkg::ST_NO_CONNECT: begin
        if (tick.auto_select) begin
          new_if        = lfc_pkg::IF_NONE;
          ctx_nxt.state = lfc_pkg::ST_START;
        end
      end
      default: begin
        // start state, unused codes behave the same
        ctx_nxt.adapter_seen = tick.eth_adapter_present;
        if (tick.auto_select) begin
          ctx_nxt.state = tick.eth_adapter_present ? lfc_pkg::ST_TRY_ETH
                                                   : lfc_pkg::ST_TRY_WIFI;
        end else begin
          new_if        = lfc_pkg::IF_OFF;
          ctx_nxt.state = lfc_pkg::ST_NO_CONNECT;
        end
      end
    endcase
    ctx_nxt.iface          = new_if;
    res.active_interface   = new_if;
    res.interface_changed  = (new_if != ctx.iface);
    res.previous_interface = ctx.iface;
  end

endmodule

// File: hdl/link_failover_controller_unit.sv
// link failover controller top level: apb registers, tick pipeline, result register
// a word goes into the input register, then into the result register that drives the outputs
// throughput: one word per cycle unless out_stall holds the result; the state update is one
// subtract-and-compare pass; while a result is held, one more word still enters the input
// register; the word after that stalls until the result register drains
// reset (rst_n low, synchronous): start state, interface none, timers and registers at defaults
module link_failover_controller_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  // poll tick channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_auto_select,
  input  logic                         in_eth_adapter_present,
  input  logic                         in_eth_link_ready,
  input  logic                         in_wifi_link_ready,
  input  logic                         in_cloud_connected,
  input  logic                         in_cloud_disconnected,
  input  logic [lfc_pkg::TIME_W-1:0]   in_now_ms,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_active_interface,
  output logic                         out_interface_changed,
  output logic [1:0]                   out_previous_interface,
  output logic                         out_eth_connect,
  output logic                         out_eth_disconnect,
  output logic                         out_wifi_connect,
  output logic                         out_wifi_disconnect,
  output logic                         out_cloud_connect,
  output logic                         out_cloud_disconnect,
  output logic                         out_keepalive_write,
  output logic [lfc_pkg::KA_W-1:0]     out_keepalive_seconds,
  output logic [1:0]                   out_led_theme,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lfc_pkg::ADDR_W-1:0]   paddr,
  input  logic [lfc_pkg::DATA_W-1:0]   pwdata,
  output logic [lfc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

`include "link_failover_controller_unit_assert.svh"

  // configuration registers
  lfc_pkg::cfg_t   cfg_r;
  lfc_pkg::cfg_t   cfg_nxt;
  logic            cfg_wr;
  logic [2:0]      reg_sel;

  // controller state carried from tick to tick
  lfc_pkg::ctx_t   ctx_r;
  lfc_pkg::ctx_t   ctx_nxt;

  // input register stage
  logic            s1_valid_r;
  logic            s1_valid_nxt;
  lfc_pkg::tick_t  s1_r;
  lfc_pkg::tick_t  tick_in;

  // result register stage
  logic            out_valid_r;
  logic            out_valid_nxt;
  lfc_pkg::res_t   out_r;
  lfc_pkg::res_t   res;

  logic            in_acc;
  logic            s1_adv;

  // ---------------------------------------------------------------------------
  // apb register file: always ready, write lands in the access phase
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_sel = paddr[4:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_sel)
        lfc_pkg::REG_ETH_LINK_TO:   cfg_nxt.eth_link_timeout_ms   = pwdata;
        lfc_pkg::REG_ETH_CLOUD_TO:  cfg_nxt.eth_cloud_timeout_ms  = pwdata;
        lfc_pkg::REG_WIFI_LINK_TO:  cfg_nxt.wifi_link_timeout_ms  = pwdata;
        lfc_pkg::REG_WIFI_CLOUD_TO: cfg_nxt.wifi_cloud_timeout_ms = pwdata;
        lfc_pkg::REG_ETH_RETRY:     cfg_nxt.eth_retry_period_ms   = pwdata;
        lfc_pkg::REG_ETH_KA:        cfg_nxt.eth_keepalive_s       = pwdata[lfc_pkg::KA_W-1:0];
        lfc_pkg::REG_WIFI_KA:       cfg_nxt.wifi_keepalive_s      = pwdata[lfc_pkg::KA_W-1:0];
        default: ;  // addresses past the register list are dropped
      endcase
    end
  end

  // read mux, keepalive registers zero-extended
  always_comb begin
    case (reg_sel)
      lfc_pkg::REG_ETH_LINK_TO:   prdata = cfg_r.eth_link_timeout_ms;
      lfc_pkg::REG_ETH_CLOUD_TO:  prdata = cfg_r.eth_cloud_timeout_ms;
      lfc_pkg::REG_WIFI_LINK_TO:  prdata = cfg_r.wifi_link_timeout_ms;
      lfc_pkg::REG_WIFI_CLOUD_TO: prdata = cfg_r.wifi_cloud_timeout_ms;
      lfc_pkg::REG_ETH_RETRY:     prdata = cfg_r.eth_retry_period_ms;
      lfc_pkg::REG_ETH_KA:
        prdata = {{(lfc_pkg::DATA_W-lfc_pkg::KA_W){1'b0}}, cfg_r.eth_keepalive_s};
      lfc_pkg::REG_WIFI_KA:
        prdata = {{(lfc_pkg::DATA_W-lfc_pkg::KA_W){1'b0}}, cfg_r.wifi_keepalive_s};
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake: the input stage moves into the result register when that
  // register is empty or being drained this cycle
  // ---------------------------------------------------------------------------
  assign s1_adv   = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~s1_adv;
  assign in_acc   = in_valid & ~in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign tick_in.auto_select         = in_auto_select;
  assign tick_in.eth_adapter_present = in_eth_adapter_present;
  assign tick_in.eth_link_ready      = in_eth_link_ready;
  assign tick_in.wifi_link_ready     = in_wifi_link_ready;
  assign tick_in.cloud_connected     = in_cloud_connected;
  assign tick_in.cloud_disconnected  = in_cloud_disconnected;
  assign tick_in.now_ms              = in_now_ms;

  // ---------------------------------------------------------------------------
  // one pass of the selection machine per word
  // ---------------------------------------------------------------------------
  lfc_fsm u_fsm (
    .tick    (s1_r),
    .cfg     (cfg_r),
    .ctx     (ctx_r),
    .ctx_nxt (ctx_nxt),
    .res     (res)
  );

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r               <= 1'b0;
      out_valid_r              <= 1'b0;
      ctx_r.state              <= lfc_pkg::ST_START;
      ctx_r.iface              <= lfc_pkg::IF_NONE;
      ctx_r.entry_time         <= '0;
      ctx_r.adapter_seen       <= 1'b0;
      cfg_r.eth_link_timeout_ms   <= lfc_pkg::RST_ETH_LINK_TO;
      cfg_r.eth_cloud_timeout_ms  <= lfc_pkg::RST_ETH_CLOUD_TO;
      cfg_r.wifi_link_timeout_ms  <= lfc_pkg::RST_WIFI_LINK_TO;
      cfg_r.wifi_cloud_timeout_ms <= lfc_pkg::RST_WIFI_CLOUD_TO;
      cfg_r.eth_retry_period_ms   <= lfc_pkg::RST_ETH_RETRY;
      cfg_r.eth_keepalive_s       <= lfc_pkg::RST_ETH_KA;
      cfg_r.wifi_keepalive_s      <= lfc_pkg::RST_WIFI_KA;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
      if (s1_adv) begin
        ctx_r <= ctx_nxt;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= tick_in;
    end
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_active_interface   = out_r.active_interface;
  assign out_interface_changed  = out_r.interface_changed;
  assign out_previous_interface = out_r.previous_interface;
  assign out_eth_connect        = out_r.eth_connect;
  assign out_eth_disconnect     = out_r.eth_disconnect;
  assign out_wifi_connect       = out_r.wifi_connect;
  assign out_wifi_disconnect    = out_r.wifi_disconnect;
  assign out_cloud_connect      = out_r.cloud_connect;
  assign out_cloud_disconnect   = out_r.cloud_disconnect;
  assign out_keepalive_write    = out_r.keepalive_write;
  assign out_keepalive_seconds  = out_r.keepalive_seconds;
  assign out_led_theme          = out_r.led_theme;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // state only moves when a word is processed
  `LFC_ASSERT_NEXT(a_ctx_hold, clk, rst_n, !s1_adv, $stable(ctx_r))
  // the off state always reports the off interface
  `LFC_ASSERT_IMPLIES(a_off_iface, clk, rst_n,
    ctx_r.state == lfc_pkg::ST_NO_CONNECT, ctx_r.iface == lfc_pkg::IF_OFF)
  // change flag agrees with the two reported interfaces
  `LFC_ASSERT_IMPLIES(a_change_flag, clk, rst_n, out_valid_r,
    out_r.interface_changed == (out_r.active_interface != out_r.previous_interface))
  // keepalive value is zero unless written
  `LFC_ASSERT_IMPLIES(a_ka_zero, clk, rst_n, out_valid_r && !out_r.keepalive_write,
    out_r.keepalive_seconds == '0)
  // an ethernet attempt always comes with the yellow theme
  `LFC_ASSERT_IMPLIES(a_eth_led, clk, rst_n, out_valid_r && out_r.eth_connect,
    out_r.led_theme == lfc_pkg::LED_YELLOW)

endmodule

// File: dv/link_failover_controller_unit_tb.sv
// self-checking testbench for the link failover controller: directed ticks, then random ticks
module link_failover_controller_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned WORDS_PER_PHASE = 150;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned MAX_REPORTS     = 10;

  // settings used by particular phases, the rest get short random timeouts
  localparam int PH_ALL_ZERO = 4;
  localparam int PH_ALL_MAX  = 5;
  localparam int PH_WIDE     = 6;

  // address that maps to no register, writes there must be ignored
  localparam logic [ADDR_W-1:0] UNUSED_REG_ADDR = 5'd28;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // one directed row: flags are {auto, adapter, eth ready, wifi ready, cloud up, cloud down}
  typedef struct packed {
    logic [5:0]        flags;
    logic [TIME_W-1:0] now;
    logic              typed;
    res_t              res;
  } dir_row_t;

  localparam res_t NO_RES = res_t'(0);
  // interface forced off from none, no commands
  localparam res_t RES_TO_OFF =
    '{IF_OFF, 1'b1, IF_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, LED_KEEP};
  // ethernet attempt kicks off: drop wifi, connect ethernet, yellow theme
  localparam res_t RES_ETH_KICK =
    '{IF_NONE, 1'b0, IF_NONE, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, LED_YELLOW};
  // cloud up over ethernet with the reset keepalive
  localparam res_t RES_ETH_KA =
    '{IF_ETH, 1'b0, IF_ETH, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd25, LED_KEEP};
  // wifi attempt kicks off: drop ethernet, connect wifi, default theme
  localparam res_t RES_WIFI_KICK =
    '{IF_NONE, 1'b0, IF_NONE, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, LED_DEFAULT};

  // directed walk through every state at reset settings, times placed on the thresholds
  dir_row_t dir_tbl [28] = '{
    '{6'b000000, 32'h0000_0000, 1'b1, RES_TO_OFF},    // start without auto select
    '{6'b100000, 32'h0000_000a, 1'b0, NO_RES},        // auto select back on, to start
    '{6'b110000, 32'h0000_0014, 1'b0, NO_RES},        // adapter seen, go ethernet
    '{6'b100000, 32'hffff_ff00, 1'b1, RES_ETH_KICK},  // entry time just below the wrap
    '{6'b100000, 32'h0000_742f, 1'b0, NO_RES},        // one ms short of the link timeout
    '{6'b101000, 32'h0000_7430, 1'b0, NO_RES},        // link ready wins over timeout
    '{6'b100010, 32'h0000_8000, 1'b1, RES_ETH_KA},    // cloud up over ethernet
    '{6'b100000, 32'h0000_a000, 1'b0, NO_RES},        // cloud lost, timer restarts
    '{6'b100000, 32'h0001_8a5f, 1'b0, NO_RES},        // one ms short of cloud timeout
    '{6'b100000, 32'h0001_8a60, 1'b0, NO_RES},        // cloud timeout, fall back
    '{6'b100000, 32'h0002_0000, 1'b1, RES_WIFI_KICK},
    '{6'b100100, 32'h0002_0010, 1'b0, NO_RES},        // wifi link ready
    '{6'b100010, 32'h0002_0020, 1'b0, NO_RES},        // cloud up over wifi
    '{6'b100010, 32'h0006_93ff, 1'b0, NO_RES},        // one ms short of the retry period
    '{6'b100010, 32'h0006_9400, 1'b0, NO_RES},        // retry period, drop the cloud
    '{6'b100001, 32'h0006_9600, 1'b0, NO_RES},        // cloud torn down, retry ethernet
    '{6'b100000, 32'h0007_0000, 1'b0, NO_RES},        // ethernet attempt starts here
    '{6'b101000, 32'h0007_e678, 1'b0, NO_RES},        // link ready late in the attempt
    '{6'b100000, 32'h0007_ea60, 1'b0, NO_RES},        // cloud timer counts from attempt start
    '{6'b100000, 32'h0008_0000, 1'b0, NO_RES},        // wifi attempt
    '{6'b100000, 32'h0008_7530, 1'b0, NO_RES},        // wifi link timeout, adapter known
    '{6'b000000, 32'h0009_0000, 1'b0, NO_RES},        // ethernet kick ignores auto select
    '{6'b000000, 32'h0009_0010, 1'b0, NO_RES},        // auto select off while waiting link
    '{6'b100000, 32'h0009_0020, 1'b0, NO_RES},        // back to start
    '{6'b100000, 32'h0009_0030, 1'b0, NO_RES},        // no adapter, go wifi
    '{6'b100000, 32'h000a_0000, 1'b0, NO_RES},
    '{6'b100000, 32'h000a_7530, 1'b0, NO_RES},        // wifi timeout without adapter, stay
    '{6'b011111, 32'hffff_ffff, 1'b1, RES_TO_OFF}     // all flags but auto select, max time
  };

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // poll tick channel, driven at the falling edge
  logic              in_valid               = 1'b0;
  logic              in_stall;
  logic              in_auto_select         = 1'b0;
  logic              in_eth_adapter_present = 1'b0;
  logic              in_eth_link_ready      = 1'b0;
  logic              in_wifi_link_ready     = 1'b0;
  logic              in_cloud_connected     = 1'b0;
  logic              in_cloud_disconnected  = 1'b0;
  logic [TIME_W-1:0] in_now_ms              = '0;

  // result channel
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [1:0]      out_active_interface;
  logic            out_interface_changed;
  logic [1:0]      out_previous_interface;
  logic            out_eth_connect;
  logic            out_eth_disconnect;
  logic            out_wifi_connect;
  logic            out_wifi_disconnect;
  logic            out_cloud_connect;
  logic            out_cloud_disconnect;
  logic            out_keepalive_write;
  logic [KA_W-1:0] out_keepalive_seconds;
  logic [1:0]      out_led_theme;

  // register port
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // mirror of the controller: state after reset and the reset register values
  ctx_t link_ctx = '{ST_START, IF_NONE, 32'd0, 1'b0};
  cfg_t link_cfg = '{RST_ETH_LINK_TO, RST_ETH_CLOUD_TO, RST_WIFI_LINK_TO, RST_WIFI_CLOUD_TO,
                     RST_ETH_RETRY, RST_ETH_KA, RST_WIFI_KA};

  res_t              due_actions [$];   // action words predicted, oldest first
  logic [TIME_W-1:0] clock_ms   = '0;   // running poll time for random ticks
  idle_mode_t        idle_mode  = IDLE_NONE;
  int unsigned       hold_left  = 0;    // receiver hold-off still to run, in cycles
  int unsigned       fail_cnt   = 0;
  int unsigned       cycle_cnt  = 0;

  link_failover_controller_unit u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_auto_select         (in_auto_select),
    .in_eth_adapter_present (in_eth_adapter_present),
    .in_eth_link_ready      (in_eth_link_ready),
    .in_wifi_link_ready     (in_wifi_link_ready),
    .in_cloud_connected     (in_cloud_connected),
    .in_cloud_disconnected  (in_cloud_disconnected),
    .in_now_ms              (in_now_ms),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_active_interface   (out_active_interface),
    .out_interface_changed  (out_interface_changed),
    .out_previous_interface (out_previous_interface),
    .out_eth_connect        (out_eth_connect),
    .out_eth_disconnect     (out_eth_disconnect),
    .out_wifi_connect       (out_wifi_connect),
    .out_wifi_disconnect    (out_wifi_disconnect),
    .out_cloud_connect      (out_cloud_connect),
    .out_cloud_disconnect   (out_cloud_disconnect),
    .out_keepalive_write    (out_keepalive_write),
    .out_keepalive_seconds  (out_keepalive_seconds),
    .out_led_theme          (out_led_theme),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  always #6 clk = ~clk;

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL link_failover_controller_unit");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // wrapping elapsed-time test against the entry time of the current state
  function automatic bit timed_out(input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] lim);
    logic [TIME_W-1:0] spent;
    spent = now - link_ctx.entry_time;
    return spent >= lim;
  endfunction

  // one poll tick through the selection machine, returns the action word it causes
  function automatic res_t advance_link_fsm(input tick_t t);
    res_t   r;
    iface_t was;
    state_t ns;
    r   = NO_RES;
    was = link_ctx.iface;
    ns  = link_ctx.state;
    case (link_ctx.state)
      ST_TRY_ETH: begin
        r.led_theme         = LED_YELLOW;
        r.wifi_disconnect   = 1'b1;
        r.eth_connect       = 1'b1;
        link_ctx.iface      = IF_NONE;
        link_ctx.entry_time = t.now_ms;
        ns = ST_WAIT_ETH_READY;
      end
      ST_WAIT_ETH_READY: begin
        if (!t.auto_select) begin
          r.eth_disconnect = 1'b1;
          link_ctx.iface   = IF_OFF;
          ns = ST_NO_CONNECT;
        end else if (t.eth_link_ready) begin
          link_ctx.iface  = IF_ETH;
          r.cloud_connect = 1'b1;
          ns = ST_WAIT_ETH_CLOUD;
        end else if (timed_out(t.now_ms, link_cfg.eth_link_timeout_ms)) begin
          link_ctx.iface = IF_NONE;
          ns = ST_TRY_WIFI;
        end
      end
      ST_WAIT_ETH_CLOUD: begin
        // no timer restart on entry from the link wait, the timeout covers the whole attempt
        if (!t.auto_select) begin
          r.eth_disconnect = 1'b1;
          link_ctx.iface   = IF_OFF;
          ns = ST_NO_CONNECT;
        end else if (t.cloud_connected) begin
          link_ctx.iface      = IF_ETH;
          r.keepalive_write   = 1'b1;
          r.keepalive_seconds = link_cfg.eth_keepalive_s;
          link_ctx.entry_time = t.now_ms;
          ns = ST_ETH_CLOUD_UP;
        end else if (timed_out(t.now_ms, link_cfg.eth_cloud_timeout_ms)) begin
          r.cloud_disconnect = 1'b1;
          r.eth_disconnect   = 1'b1;
          ns = ST_TRY_WIFI;
        end
      end
      ST_ETH_CLOUD_UP: begin
        if (!t.auto_select) begin
          r.cloud_disconnect = 1'b1;
          r.eth_disconnect   = 1'b1;
          link_ctx.iface     = IF_OFF;
          ns = ST_NO_CONNECT;
        end else if (!t.cloud_connected) begin
          link_ctx.iface      = IF_NONE;
          link_ctx.entry_time = t.now_ms;
          ns = ST_WAIT_ETH_CLOUD;
        end
      end
      ST_TRY_WIFI: begin
        link_ctx.iface      = IF_NONE;
        r.led_theme         = LED_DEFAULT;
        link_ctx.entry_time = t.now_ms;
        r.eth_disconnect    = 1'b1;
        r.wifi_connect      = 1'b1;
        ns = ST_WAIT_WIFI_READY;
      end
      ST_WAIT_WIFI_READY: begin
        if (!t.auto_select) begin
          link_ctx.iface = IF_OFF;
          ns = ST_NO_CONNECT;
        end else if (t.wifi_link_ready) begin
          link_ctx.iface  = IF_WIFI;
          r.cloud_connect = 1'b1;
          ns = ST_WAIT_WIFI_CLOUD;
        end else if (timed_out(t.now_ms, link_cfg.wifi_link_timeout_ms) &&
                     link_ctx.adapter_seen) begin
          link_ctx.iface = IF_NONE;
          ns = ST_TRY_ETH;
        end
      end
      ST_WAIT_WIFI_CLOUD: begin
        if (!t.auto_select) begin
          r.cloud_disconnect = 1'b1;
          r.wifi_disconnect  = 1'b1;
          link_ctx.iface     = IF_OFF;
          ns = ST_NO_CONNECT;
        end else if (t.cloud_connected) begin
          r.keepalive_write   = 1'b1;
          r.keepalive_seconds = link_cfg.wifi_keepalive_s;
          link_ctx.iface      = IF_WIFI;
          link_ctx.entry_time = t.now_ms;
          ns = ST_WIFI_CLOUD_UP;
        end else if (timed_out(t.now_ms, link_cfg.wifi_cloud_timeout_ms) &&
                     link_ctx.adapter_seen) begin
          r.cloud_disconnect = 1'b1;
          link_ctx.iface     = IF_NONE;
          ns = ST_TRY_ETH;
        end
      end
      ST_WIFI_CLOUD_UP: begin
        if (!t.auto_select) begin
          r.cloud_disconnect = 1'b1;
          r.wifi_disconnect  = 1'b1;
          link_ctx.iface     = IF_OFF;
          ns = ST_NO_CONNECT;
        end else if (!t.cloud_connected) begin
          link_ctx.iface      = IF_NONE;
          link_ctx.entry_time = t.now_ms;
          ns = ST_WAIT_WIFI_CLOUD;
        end else if (timed_out(t.now_ms, link_cfg.eth_retry_period_ms) &&
                     link_ctx.adapter_seen) begin
          r.cloud_disconnect = 1'b1;
          link_ctx.iface     = IF_NONE;
          ns = ST_WIFI_WAIT_DOWN;
        end
      end
      ST_WIFI_WAIT_DOWN: begin
        if (!t.auto_select) begin
          r.cloud_disconnect = 1'b1;
          r.wifi_disconnect  = 1'b1;
          link_ctx.iface     = IF_OFF;
          ns = ST_NO_CONNECT;
        end else if (t.cloud_disconnected) begin
          ns = ST_TRY_ETH;
        end
      end
      ST_NO_CONNECT: begin
        if (t.auto_select) begin
          link_ctx.iface = IF_NONE;
          ns = ST_START;
        end
      end
      default: begin
        // start: the only place the adapter flag is sampled
        link_ctx.adapter_seen = t.eth_adapter_present;
        if (t.auto_select) begin
          ns = t.eth_adapter_present ? ST_TRY_ETH : ST_TRY_WIFI;
        end else begin
          ns = ST_NO_CONNECT;
          link_ctx.iface = IF_OFF;
        end
      end
    endcase
    link_ctx.state = ns;
    r.active_interface   = link_ctx.iface;
    r.interface_changed  = (link_ctx.iface != was);
    r.previous_interface = was;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] cfg_field(input cfg_t c, input reg_idx_t idx);
    case (idx)
      REG_ETH_LINK_TO:   return c.eth_link_timeout_ms;
      REG_ETH_CLOUD_TO:  return c.eth_cloud_timeout_ms;
      REG_WIFI_LINK_TO:  return c.wifi_link_timeout_ms;
      REG_WIFI_CLOUD_TO: return c.wifi_cloud_timeout_ms;
      REG_ETH_RETRY:     return c.eth_retry_period_ms;
      REG_ETH_KA:        return {{(DATA_W-KA_W){1'b0}}, c.eth_keepalive_s};
      default:           return {{(DATA_W-KA_W){1'b0}}, c.wifi_keepalive_s};
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic cfg_t settings_for_phase(input int p);
    cfg_t c;
    if (p == PH_ALL_ZERO) begin
      c = '0;
    end else if (p == PH_ALL_MAX) begin
      c = '1;
    end else if (p == PH_WIDE) begin
      c = cfg_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                  16'($urandom), 16'($urandom)});
    end else begin
      // short timeouts so that every timeout path fires often
      c.eth_link_timeout_ms   = $urandom_range(0, 60);
      c.eth_cloud_timeout_ms  = $urandom_range(0, 60);
      c.wifi_link_timeout_ms  = $urandom_range(0, 60);
      c.wifi_cloud_timeout_ms = $urandom_range(0, 60);
      c.eth_retry_period_ms   = $urandom_range(0, 60);
      c.eth_keepalive_s       = KA_W'($urandom_range(0, 65535));
      c.wifi_keepalive_s      = KA_W'($urandom_range(0, 65535));
    end
    return c;
  endfunction

  // random tick shaped by the mirrored state so that deep states get reached
  function automatic tick_t make_tick();
    tick_t             t;
    int unsigned       pick;
    logic [TIME_W-1:0] lim;
    t.auto_select         = ($urandom_range(0, 99) < 92);
    t.eth_adapter_present = ($urandom_range(0, 99) < 70);
    t.eth_link_ready      = ($urandom_range(0, 99) < 30);
    t.wifi_link_ready     = ($urandom_range(0, 99) < 30);
    // a live cloud session mostly stays up, elsewhere it comes up now and then
    if (link_ctx.state == ST_ETH_CLOUD_UP || link_ctx.state == ST_WIFI_CLOUD_UP) begin
      t.cloud_connected = ($urandom_range(0, 99) < 85);
    end else begin
      t.cloud_connected = ($urandom_range(0, 99) < 30);
    end
    t.cloud_disconnected = ($urandom_range(0, 99) < 35);
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // land one ms before, on, or one ms after some configured limit
      lim = cfg_field(link_cfg, reg_idx_t'($urandom_range(0, int'(REG_ETH_RETRY))));
      clock_ms = link_ctx.entry_time + lim + TIME_W'($urandom_range(0, 2)) - 1'b1;
    end else if (pick < 15) begin
      clock_ms = $urandom;
    end else begin
      clock_ms = clock_ms + TIME_W'($urandom_range(0, 40));
    end
    t.now_ms = clock_ms;
    return t;
  endfunction

  function automatic bit sender_rests();
    case (idle_mode)
      IDLE_SENDER: return ($urandom_range(0, 99) < 76);
      IDLE_BOTH:   return ($urandom_range(0, 99) < 9);
      default:     return 1'b0;
    endcase
  endfunction

  // offer one tick word, wait for it to be taken, then record the action word due
  task automatic send_tick(input tick_t t, input logic typed, input res_t typed_res);
    res_t pred;
    @(negedge clk);
    while (sender_rests()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid               <= 1'b1;
    in_auto_select         <= t.auto_select;
    in_eth_adapter_present <= t.eth_adapter_present;
    in_eth_link_ready      <= t.eth_link_ready;
    in_wifi_link_ready     <= t.wifi_link_ready;
    in_cloud_connected     <= t.cloud_connected;
    in_cloud_disconnected  <= t.cloud_disconnected;
    in_now_ms              <= t.now_ms;
    do @(posedge clk); while (in_stall);
    // the mirror always steps, a typed row just replaces the word it expects
    pred = advance_link_fsm(t);
    due_actions.push_back(typed ? typed_res : pred);
  endtask

  // sender goes quiet until every action word due has come out
  task automatic wait_drained();
    @(negedge clk) in_valid <= 1'b0;
    while (due_actions.size() != 0) @(posedge clk);
  endtask

  // one register access: setup cycle, then access cycle until pready
  task automatic reg_access(input logic wr, input logic [ADDR_W-1:0] a,
                            input logic [DATA_W-1:0] d, output logic [DATA_W-1:0] rd);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // read every register back and compare with the mirrored settings
  task automatic verify_settings();
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] rd;
    logic [DATA_W-1:0] want;
    for (int i = 0; i <= int'(REG_WIFI_KA); i++) begin
      a    = ADDR_W'(i * 4);
      want = cfg_field(link_cfg, reg_idx_t'(i));
      reg_access(1'b0, a, '0, rd);
      if (rd !== want) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) begin
          $display("register %0d reads %h, expected %h", i, rd, want);
        end
      end
    end
  endtask

  // write all registers, junk in the unused upper half of the keepalive ones,
  // plus a write to the address past the last register that must change nothing
  task automatic load_settings(input cfg_t c);
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    logic [DATA_W-1:0] rd;
    for (int i = 0; i <= int'(REG_WIFI_KA); i++) begin
      a = ADDR_W'(i * 4);
      d = cfg_field(c, reg_idx_t'(i));
      if (reg_idx_t'(i) == REG_ETH_KA || reg_idx_t'(i) == REG_WIFI_KA) begin
        d[DATA_W-1:KA_W] = (DATA_W-KA_W)'($urandom);
      end
      reg_access(1'b1, a, d, rd);
    end
    reg_access(1'b1, UNUSED_REG_ADDR, $urandom, rd);
    link_cfg = c;
    verify_settings();
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stall, or a long hold-off counted down here
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      case (idle_mode)
        IDLE_RECEIVER: out_stall <= ($urandom_range(0, 99) < 76);
        IDLE_BOTH:     out_stall <= ($urandom_range(0, 99) < 9);
        default:       out_stall <= 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every word taken is compared against the oldest one due
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{iface_t'(out_active_interface), out_interface_changed,
              iface_t'(out_previous_interface), out_eth_connect, out_eth_disconnect,
              out_wifi_connect, out_wifi_disconnect, out_cloud_connect,
              out_cloud_disconnect, out_keepalive_write, out_keepalive_seconds,
              led_t'(out_led_theme)};
      if (due_actions.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) begin
          $display("action word with none due: if %0d chg %0d", got.active_interface,
                   got.interface_changed);
        end
      end else begin
        want = due_actions.pop_front();
        if (got !== want) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS) begin
            // cmd bits: eth con/dis, wifi con/dis, cloud con/dis
            $write("action word mismatch (exp/act): if %0d/%0d chg %0b/%0b prev %0d/%0d ",
                   want.active_interface, got.active_interface,
                   want.interface_changed, got.interface_changed,
                   want.previous_interface, got.previous_interface);
            $display("cmd %b/%b ka %0b:%0d/%0b:%0d led %0d/%0d",
                     {want.eth_connect, want.eth_disconnect, want.wifi_connect,
                      want.wifi_disconnect, want.cloud_connect, want.cloud_disconnect},
                     {got.eth_connect, got.eth_disconnect, got.wifi_connect,
                      got.wifi_disconnect, got.cloud_connect, got.cloud_disconnect},
                     want.keepalive_write, want.keepalive_seconds,
                     got.keepalive_write, got.keepalive_seconds,
                     want.led_theme, got.led_theme);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    tick_t tk;
    // reset held low from the start, released at a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // registers must come out of reset at their defaults
    verify_settings();

    // directed walk at reset settings, no idling
    foreach (dir_tbl[i]) begin
      tk = tick_t'({dir_tbl[i].flags, dir_tbl[i].now});
      send_tick(tk, dir_tbl[i].typed, dir_tbl[i].res);
    end

    // random phases, each with its own settings and idling pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      load_settings(settings_for_phase(p));
      idle_mode = idle_mode_t'(p % 4);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // long receiver hold-off while the sender keeps offering, fills the block
        if (p == 0 && n == 30) begin
          hold_left = HOLD_CYCLES;
        end
        // sender pauses until every due word is out
        if (n == WORDS_PER_PHASE / 2) begin
          wait_drained();
        end
        send_tick(make_tick(), 1'b0, NO_RES);
      end
    end

    // let the pipeline settle
    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_cnt == 0 && due_actions.size() == 0) begin
      $display("PASS link_failover_controller_unit");
    end else begin
      $display("FAIL link_failover_controller_unit");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/lfc_pkg.sv
hdl/lfc_fsm.sv
hdl/link_failover_controller_unit.sv
dv/link_failover_controller_unit_tb.sv
